### rtl/core/mbt_pkg.sv
// package: token kinds, lexer modes, keyword matching and result types
package mbt_pkg;

  localparam int LINE_BITS = 24;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;
  localparam int KEYWORD_CHARS = 15;
  localparam int PREFIX_IDX_BITS = $clog2(KEYWORD_CHARS);
  localparam int MAX_RESULTS = 3;

  localparam logic [5:0] K_NUMBER = 6'd0;
  localparam logic [5:0] K_STRING = 6'd1;
  localparam logic [5:0] K_IDENT = 6'd2;
  localparam logic [5:0] K_SOLID = 6'd3;
  localparam logic [5:0] K_LIQUID = 6'd4;
  localparam logic [5:0] K_GAS = 6'd5;
  localparam logic [5:0] K_PLASMA = 6'd6;
  localparam logic [5:0] K_PLUS = 6'd7;
  localparam logic [5:0] K_MINUS = 6'd8;
  localparam logic [5:0] K_STAR = 6'd9;
  localparam logic [5:0] K_SLASH = 6'd10;
  localparam logic [5:0] K_CARET = 6'd11;
  localparam logic [5:0] K_ASSIGN = 6'd12;
  localparam logic [5:0] K_EQEQ = 6'd13;
  localparam logic [5:0] K_NEQ = 6'd14;
  localparam logic [5:0] K_LT = 6'd15;
  localparam logic [5:0] K_GT = 6'd16;
  localparam logic [5:0] K_LE = 6'd17;
  localparam logic [5:0] K_GE = 6'd18;
  localparam logic [5:0] K_LPAREN = 6'd19;
  localparam logic [5:0] K_RPAREN = 6'd20;
  localparam logic [5:0] K_LBRACE = 6'd21;
  localparam logic [5:0] K_RBRACE = 6'd22;
  localparam logic [5:0] K_LBRACK = 6'd23;
  localparam logic [5:0] K_RBRACK = 6'd24;
  localparam logic [5:0] K_SEMI = 6'd25;
  localparam logic [5:0] K_COMMA = 6'd26;
  localparam logic [5:0] K_DOT = 6'd27;
  localparam logic [5:0] K_COLON = 6'd28;
  localparam logic [5:0] K_ELEMENT = 6'd29;
  localparam logic [5:0] K_MATERIAL = 6'd30;
  localparam logic [5:0] K_BEHAVIOR = 6'd31;
  localparam logic [5:0] K_BOT = 6'd32;
  localparam logic [5:0] K_END = 6'd33;
  localparam logic [5:0] K_ERROR = 6'd34;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNTERM = 2'd1;
  localparam logic [1:0] E_BANG = 2'd2;
  localparam logic [1:0] E_BYTE = 2'd3;

  localparam logic [1:0] KS_MARKUP = 2'd0;
  localparam logic [1:0] KS_STYLE = 2'd1;
  localparam logic [1:0] KS_BEHAVIOR = 2'd2;
  localparam logic [1:0] KS_BOT = 2'd3;

  localparam logic [0:0] CFG_KEYWORD_SET = 1'd0;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_EXP0, M_EXPD, M_STR, M_ESC,
    M_COMMENT, M_SLASH, M_EQ, M_BANG, M_LT, M_GT
  } mode_t;

  typedef struct packed {
    logic [5:0] token_kind;
    logic [1:0] error_kind;
    logic [7:0] bad_byte;
    logic [LENGTH_BITS-1:0] token_length;
    logic [LINE_BITS-1:0] line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic last_of_run;
  } result_t;

  typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

  // compare the held prefix with a fixed word of up to KEYWORD_CHARS letters
  function automatic logic word_is(input prefix_t p, input logic [LENGTH_BITS-1:0] len,
                                   input logic [8*KEYWORD_CHARS-1:0] w, input int wl);
    logic ok;
    ok = (len == LENGTH_BITS'(wl));
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (i < wl && p[i] != w[8*(wl-1-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [5:0] classify(input prefix_t p, input logic [LENGTH_BITS-1:0] len,
                                          input logic [1:0] ks);
    logic [5:0] k;
    k = K_IDENT;
    if (len <= LENGTH_BITS'(KEYWORD_CHARS)) begin
      if (word_is(p, len, "solid", 5)) k = K_SOLID;
      if (word_is(p, len, "liquid", 6)) k = K_LIQUID;
      if (word_is(p, len, "gas", 3)) k = K_GAS;
      if (word_is(p, len, "plasma", 6)) k = K_PLASMA;
      unique case (ks)
        KS_MARKUP: begin
          if (word_is(p, len, "element", 7) || word_is(p, len, "sphere", 6) ||
              word_is(p, len, "shell", 5) || word_is(p, len, "point", 5)) k = K_ELEMENT;
          if (word_is(p, len, "material", 8)) k = K_MATERIAL;
          if (word_is(p, len, "behavior", 8)) k = K_BEHAVIOR;
        end
        KS_STYLE: begin
          if (word_is(p, len, "material", 8) || word_is(p, len, "animation", 9) ||
              word_is(p, len, "keyframe", 8) || word_is(p, len, "transition", 10))
            k = K_MATERIAL;
        end
        KS_BEHAVIOR: begin
          if (word_is(p, len, "behavior", 8) || word_is(p, len, "physics", 7) ||
              word_is(p, len, "force", 5) || word_is(p, len, "collision", 9))
            k = K_BEHAVIOR;
        end
        KS_BOT: begin
          if (word_is(p, len, "bot", 3) || word_is(p, len, "agent", 5) ||
              word_is(p, len, "parallel", 8) || word_is(p, len, "distributed", 11))
            k = K_BOT;
        end
        default: k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      "^": k = K_CARET;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      ".": k = K_DOT;
      ":": k = K_COLON;
      default: k = K_NUMBER;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/mbt_if.sv
// valid/ready channel interfaces for source bytes and tokens
interface mbt_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] byte_value;
  logic end_of_source;
  modport source (output valid, byte_value, end_of_source, input ready);
  modport sink (input valid, byte_value, end_of_source, output ready);
endinterface

interface mbt_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [5:0] token_kind;
  logic [1:0] error_kind;
  logic [7:0] bad_byte;
  logic [mbt_pkg::LENGTH_BITS-1:0] token_length;
  logic [mbt_pkg::LINE_BITS-1:0] line_number;
  logic [mbt_pkg::COLUMN_BITS-1:0] column_number;
  logic last_of_run;
  modport source (output valid, token_kind, error_kind, bad_byte, token_length,
                  line_number, column_number, last_of_run, input ready);
  modport sink (input valid, token_kind, error_kind, bad_byte, token_length,
                line_number, column_number, last_of_run, output ready);
endinterface

### rtl/core/mbt_lexer.sv
// lexer step: next state and up to three results for one source byte
module mbt_lexer (
  input  logic [7:0] byte_value,
  input  logic end_of_source,
  input  logic [1:0] keyword_set,
  input  mbt_pkg::mode_t mode,
  input  logic quote_kind,
  input  logic [mbt_pkg::LINE_BITS-1:0] line_count,
  input  logic [mbt_pkg::COLUMN_BITS-1:0] column_count,
  input  logic [mbt_pkg::LENGTH_BITS-1:0] length_count,
  input  mbt_pkg::prefix_t prefix,
  output mbt_pkg::mode_t mode_nxt,
  output logic quote_nxt,
  output logic [mbt_pkg::LINE_BITS-1:0] line_nxt,
  output logic [mbt_pkg::COLUMN_BITS-1:0] column_nxt,
  output logic [mbt_pkg::LENGTH_BITS-1:0] length_nxt,
  output logic prefix_we,
  output logic [mbt_pkg::PREFIX_IDX_BITS-1:0] prefix_idx,
  output logic [1:0] res_count,
  output mbt_pkg::result_t [mbt_pkg::MAX_RESULTS-1:0] res
);
  import mbt_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
  localparam logic [COLUMN_BITS-1:0] COL_TOP = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_TOP = '1;

  logic [LINE_BITS-1:0] ln;
  logic [COLUMN_BITS-1:0] col;
  logic [LENGTH_BITS-1:0] len;
  logic [1:0] n;
  logic b_digit, b_alpha, b_ws;
  logic do_start;
  logic [5:0] sk;
  logic [5:0] held_k;
  logic [1:0] held_e;

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] c);
    return (c < COL_TOP) ? c + COLUMN_BITS'(1) : c;
  endfunction

  always_comb begin
    b_digit = byte_value >= "0" && byte_value <= "9";
    b_alpha = (byte_value >= "a" && byte_value <= "z") ||
              (byte_value >= "A" && byte_value <= "Z") || byte_value == "_";
    b_ws = byte_value == " " || byte_value == 8'h09 || byte_value == 8'h0d ||
           byte_value == 8'h0a;
    sk = single_kind(byte_value);
    held_k = K_ERROR;
    held_e = E_BANG;
    case (mode)
      M_SLASH: begin held_k = K_SLASH; held_e = E_NONE; end
      M_EQ:    begin held_k = K_ASSIGN; held_e = E_NONE; end
      M_LT:    begin held_k = K_LT; held_e = E_NONE; end
      M_GT:    begin held_k = K_GT; held_e = E_NONE; end
      default: ;
    endcase

    ln = line_count;
    col = column_count;
    len = length_count;
    n = 2'd0;
    res = '0;
    mode_nxt = mode;
    quote_nxt = quote_kind;
    prefix_we = 1'b0;
    prefix_idx = '0;
    do_start = 1'b0;

    if (end_of_source) begin
      case (mode)
        M_IDENT: begin
          res[n] = '{classify(prefix, len, keyword_set), E_NONE, 8'd0, len, ln, col, 1'b0};
          n = n + 2'd1;
        end
        M_INT, M_FRAC, M_EXP0, M_EXPD: begin
          res[n] = '{K_NUMBER, E_NONE, 8'd0, len, ln, col, 1'b0};
          n = n + 2'd1;
        end
        M_DOT: begin
          res[n] = '{K_NUMBER, E_NONE, 8'd0, len, ln, col, 1'b0};
          n = n + 2'd1;
          col = col_inc(col);
          res[n] = '{K_DOT, E_NONE, 8'd0, LENGTH_BITS'(1), ln, col, 1'b0};
          n = n + 2'd1;
        end
        M_STR, M_ESC: begin
          res[n] = '{K_ERROR, E_UNTERM, 8'd0, len, ln, col, 1'b0};
          n = n + 2'd1;
        end
        M_SLASH, M_EQ, M_BANG, M_LT, M_GT: begin
          col = col_inc(col);
          res[n] = '{held_k, held_e, 8'd0, LENGTH_BITS'(1), ln, col, 1'b0};
          n = n + 2'd1;
        end
        default: ;
      endcase
      res[n] = '{K_END, E_NONE, 8'd0, '0, ln, col, 1'b0};
      n = n + 2'd1;
      mode_nxt = M_IDLE;
      quote_nxt = 1'b0;
      ln = LINE_BITS'(1);
      col = COLUMN_BITS'(1);
      len = '0;
    end else begin
      case (mode)
        M_IDENT: begin
          if (b_alpha || b_digit) begin
            if (len < LENGTH_BITS'(KEYWORD_CHARS)) begin
              prefix_we = 1'b1;
              prefix_idx = len[PREFIX_IDX_BITS-1:0];
            end
            col = col_inc(col);
            if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
          end else begin
            res[n] = '{classify(prefix, len, keyword_set), E_NONE, 8'd0, len, ln, col, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (b_digit) begin
            col = col_inc(col);
            if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
          end else if (mode == M_INT && byte_value == ".") begin
            mode_nxt = M_DOT;
          end else if (byte_value == "e" || byte_value == "E") begin
            col = col_inc(col);
            if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
            mode_nxt = M_EXP0;
          end else begin
            res[n] = '{K_NUMBER, E_NONE, 8'd0, len, ln, col, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_DOT: begin
          if (b_digit) begin
            col = col_inc(col_inc(col));
            if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
            if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
            mode_nxt = M_FRAC;
          end else begin
            res[n] = '{K_NUMBER, E_NONE, 8'd0, len, ln, col, 1'b0};
            n = n + 2'd1;
            col = col_inc(col);
            res[n] = '{K_DOT, E_NONE, 8'd0, LENGTH_BITS'(1), ln, col, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_EXP0, M_EXPD: begin
          if (b_digit || (mode == M_EXP0 && (byte_value == "+" || byte_value == "-"))) begin
            col = col_inc(col);
            if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
            mode_nxt = M_EXPD;
          end else begin
            res[n] = '{K_NUMBER, E_NONE, 8'd0, len, ln, col, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_STR: begin
          col = col_inc(col);
          if (byte_value == (quote_kind ? 8'h27 : 8'h22)) begin
            res[n] = '{K_STRING, E_NONE, 8'd0, len, ln, col, 1'b0};
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            // newline inside a string still moves to the next line
            if (byte_value == 8'h0a) begin
              if (ln < LINE_TOP) ln = ln + LINE_BITS'(1);
              col = COLUMN_BITS'(1);
            end
            if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
            if (byte_value == 8'h5c) mode_nxt = M_ESC;
          end
        end
        M_ESC: begin
          if (byte_value == 8'h0a) begin
            if (ln < LINE_TOP) ln = ln + LINE_BITS'(1);
            col = COLUMN_BITS'(1);
          end else col = col_inc(col);
          if (len < LEN_TOP) len = len + LENGTH_BITS'(1);
          mode_nxt = M_STR;
        end
        M_COMMENT: begin
          if (byte_value == 8'h0a) do_start = 1'b1;
          else col = col_inc(col);
        end
        M_SLASH: begin
          if (byte_value == "/") begin
            col = col_inc(col_inc(col));
            mode_nxt = M_COMMENT;
          end else begin
            col = col_inc(col);
            res[n] = '{held_k, held_e, 8'd0, LENGTH_BITS'(1), ln, col, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        M_EQ, M_BANG, M_LT, M_GT: begin
          col = col_inc(col);
          if (byte_value == "=") begin
            col = col_inc(col);
            res[n] = '{(mode == M_EQ) ? K_EQEQ : (mode == M_BANG) ? K_NEQ :
                       (mode == M_LT) ? K_LE : K_GE,
                       E_NONE, 8'd0, LENGTH_BITS'(2), ln, col, 1'b0};
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[n] = '{held_k, held_e, 8'd0, LENGTH_BITS'(1), ln, col, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_nxt = M_IDLE;
        if (b_ws) begin
          if (byte_value == 8'h0a) begin
            if (ln < LINE_TOP) ln = ln + LINE_BITS'(1);
            col = COLUMN_BITS'(1);
          end else col = col_inc(col);
        end else if (b_digit) begin
          col = col_inc(col);
          len = LENGTH_BITS'(1);
          mode_nxt = M_INT;
        end else if (b_alpha) begin
          col = col_inc(col);
          len = LENGTH_BITS'(1);
          prefix_we = 1'b1;
          prefix_idx = '0;
          mode_nxt = M_IDENT;
        end else if (byte_value == 8'h22 || byte_value == 8'h27) begin
          col = col_inc(col);
          len = '0;
          quote_nxt = byte_value == 8'h27;
          mode_nxt = M_STR;
        end else if (byte_value == "/") mode_nxt = M_SLASH;
        else if (byte_value == "=") mode_nxt = M_EQ;
        else if (byte_value == "!") mode_nxt = M_BANG;
        else if (byte_value == "<") mode_nxt = M_LT;
        else if (byte_value == ">") mode_nxt = M_GT;
        else begin
          col = col_inc(col);
          if (sk != K_NUMBER)
            res[n] = '{sk, E_NONE, 8'd0, LENGTH_BITS'(1), ln, col, 1'b0};
          else
            res[n] = '{K_ERROR, E_BYTE, byte_value, LENGTH_BITS'(1), ln, col, 1'b0};
          n = n + 2'd1;
        end
      end
    end

    if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
    res_count = n;
    line_nxt = ln;
    column_nxt = col;
    length_nxt = len;
  end
endmodule

### rtl/core/markup_byte_tokenizer_unit.sv
// top level: byte lexer with registered state, result queue and register port
// At most one source byte or end marker is taken per clock and all of its results (up to
// three) are formed in that same cycle from the lexer state; they land in a small
// result queue of eight entries and show on the output from the next cycle, one token
// per beat, each with the line and column just after it. The input is taken only while
// that queue has room for three more, so with the output always ready a byte goes in
// every cycle unless tokens pile up faster than one per cycle. The keyword set register
// sits at byte address 0 of the register port.
module markup_byte_tokenizer_unit (
  input  logic clk,
  input  logic rst_n,
  mbt_in_if.sink in_ch,
  mbt_out_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import mbt_pkg::*;

  localparam int QDEPTH = 8;
  localparam int QBITS = $clog2(QDEPTH);

  logic [1:0] keyword_set_r;
  mode_t mode_r, mode_nxt;
  logic quote_r, quote_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  prefix_t prefix_r;
  logic prefix_we;
  logic [PREFIX_IDX_BITS-1:0] prefix_idx;
  logic [1:0] res_count;
  result_t [MAX_RESULTS-1:0] res;

  result_t [QDEPTH-1:0] q_r;
  logic [QBITS-1:0] wp_r, rp_r;
  logic [QBITS:0] cnt_r;
  logic take, give;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_KEYWORD_SET) ? {30'd0, keyword_set_r} : 32'd0;

  assign in_ch.ready = cnt_r <= (QBITS+1)'(QDEPTH - MAX_RESULTS);
  assign take = in_ch.valid && in_ch.ready;
  assign give = out_ch.valid && out_ch.ready;

  mbt_lexer u_lexer (
    .byte_value(in_ch.byte_value), .end_of_source(in_ch.end_of_source),
    .keyword_set(keyword_set_r), .mode(mode_r), .quote_kind(quote_r),
    .line_count(line_r), .column_count(col_r), .length_count(len_r),
    .prefix(prefix_r), .mode_nxt(mode_nxt), .quote_nxt(quote_nxt),
    .line_nxt(line_nxt), .column_nxt(col_nxt), .length_nxt(len_nxt),
    .prefix_we(prefix_we), .prefix_idx(prefix_idx),
    .res_count(res_count), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyword_set_r <= KS_MARKUP;
      mode_r <= M_IDLE;
      quote_r <= 1'b0;
      line_r <= LINE_BITS'(1);
      col_r <= COLUMN_BITS'(1);
      len_r <= '0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == CFG_KEYWORD_SET) keyword_set_r <= cfg_pwdata[1:0];
      if (take) begin
        mode_r <= mode_nxt;
        quote_r <= quote_nxt;
        line_r <= line_nxt;
        col_r <= col_nxt;
        len_r <= len_nxt;
        wp_r <= wp_r + QBITS'(res_count);
      end
      if (give) rp_r <= rp_r + QBITS'(1);
      cnt_r <= cnt_r + (take ? (QBITS+1)'(res_count) : '0) - (give ? (QBITS+1)'(1) : '0);
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (take) begin
      if (prefix_we) prefix_r[prefix_idx] <= in_ch.byte_value;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (2'(i) < res_count) q_r[wp_r + QBITS'(i)] <= res[i];
      end
    end
  end

  assign out_ch.valid = cnt_r != '0;
  assign out_ch.token_kind = q_r[rp_r].token_kind;
  assign out_ch.error_kind = q_r[rp_r].error_kind;
  assign out_ch.bad_byte = q_r[rp_r].bad_byte;
  assign out_ch.token_length = q_r[rp_r].token_length;
  assign out_ch.line_number = q_r[rp_r].line_number;
  assign out_ch.column_number = q_r[rp_r].column_number;
  assign out_ch.last_of_run = q_r[rp_r].last_of_run;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QBITS+1)'(QDEPTH)) else $error("result queue overflow");
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_ch.end_of_source |=> mode_r == M_IDLE && line_r == LINE_BITS'(1))
    else $error("end of source did not clear lexer");
  a_some_result_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_ch.end_of_source |=> cnt_r != '0) else $error("end token missing");
endmodule
